/* hdl/gsbd_pkg.sv */
`timescale 1ns / 1ps

package gsbd_pkg;

	// default divisor width and fixed field widths
	localparam int DIVISOR_BITS_DEF = 16;
	localparam int DIVISOR_BITS_MAX = 31;
	localparam int QUOT_BITS        = 32;
	localparam int VALUE_BITS       = 32;
	localparam int STATUS_BITS      = 2;
	localparam int CFG_INDEX_BITS   = 8;
	localparam int CFG_DATA_BITS    = 32;
	localparam int M_RESET          = 3;

	// largest magnitude a decoded number may reach before mapping
	localparam logic [63:0] VALUE_LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

	// result status codes
	localparam logic [STATUS_BITS-1:0] ST_OK  = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_END = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_REM = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_OVF = 2'd3;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_GOLOMB_M  = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIGN_MODE = 8'd1;

	// code word phase
	typedef enum logic [1:0] {
		PH_UNARY = 2'd0,
		PH_REM   = 2'd1,
		PH_EXTRA = 2'd2
	} phase_t;

	// remainder width: smallest b with 2^b >= m (m at least one)
	function automatic logic [4:0] width_of_m(input logic [DIVISOR_BITS_MAX-1:0] m);
		logic [DIVISOR_BITS_MAX-1:0] m1;
		logic [4:0]                  b;
		m1 = m - 1'b1;
		b  = 5'd0;
		for (int i = 0; i < DIVISOR_BITS_MAX; i++) begin
			if (m1[i]) begin
				b = 5'(i + 1);
			end
		end
		return b;
	endfunction

endpackage

/* hdl/gsbd_in_if.sv */
`timescale 1ns / 1ps

interface gsbd_in_if;
	logic valid;
	logic ready;
	logic code_bit;
	logic stream_end;

	modport source (output valid, output code_bit, output stream_end, input ready);
	modport sink   (input valid, input code_bit, input stream_end, output ready);
endinterface

/* hdl/gsbd_out_if.sv */
`timescale 1ns / 1ps

interface gsbd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gsbd_pkg::VALUE_BITS-1:0]  decoded_value;
	logic        [gsbd_pkg::STATUS_BITS-1:0] status;

	modport source (output valid, output decoded_value, output status, input ready);
	modport sink   (input valid, input decoded_value, input status, output ready);
endinterface

/* hdl/gsbd_cfg_if.sv */
`timescale 1ns / 1ps

interface gsbd_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [gsbd_pkg::CFG_INDEX_BITS-1:0]   index;
	logic [gsbd_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/golomb_signed_bit_decoder_core.sv */
`timescale 1ns / 1ps

// channel     dir  handshake            payload
// cfg         in   valid / ready        index, data (0 golomb_m, 1 sign_mode)
// bits_in     in   valid / ready        code_bit, stream_end
// result_out  out  valid / ready        decoded_value, status
//
// one stream bit per cycle is taken while ready; code word state updates as it is taken.
// a finished word goes through four registers (capture, q*M product, sum and range
// check, signed mapping) before its result shows.
// the q*M multiplier sets the length of the product stage.
// reset clears the word state, the pipeline valids and sets M to 3, sign-magnitude.
// stages close gaps; input stalls only with all four stages full and output not ready.

module golomb_signed_bit_decoder_core #(
	parameter int DIVISOR_BITS = gsbd_pkg::DIVISOR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	gsbd_cfg_if.sink      cfg,
	gsbd_in_if.sink       bits_in,
	gsbd_out_if.source    result_out
);

	localparam int DB  = DIVISOR_BITS;
	localparam int BW  = $clog2(DB + 1);
	localparam int QB  = gsbd_pkg::QUOT_BITS;
	localparam int PW  = QB + DB;
	localparam int NW  = PW + 1;
	localparam int VB  = gsbd_pkg::VALUE_BITS;
	localparam int SB  = gsbd_pkg::STATUS_BITS;
	localparam logic [DB-1:0] M_RST = DB'(gsbd_pkg::M_RESET);
	localparam logic [4:0]    B_RST =
		gsbd_pkg::width_of_m(gsbd_pkg::DIVISOR_BITS_MAX'(M_RST));
	localparam logic [DB:0]   T_RST = ((DB+1)'(1) << B_RST) - {1'b0, M_RST};

	// configuration registers
	logic [DB-1:0] m_q;
	logic [BW-1:0] b_q;
	logic [DB-1:0] t_q;
	logic          sign_q;

	// code word state
	gsbd_pkg::phase_t ph_q, ph_d;
	logic [QB-1:0] quot_q, quot_d;
	logic [DB:0]   acc_q, acc_d;
	logic [BW-1:0] rd_q, rd_d;
	logic          ws_q, ws_d;

	// pipeline
	logic          v_s1, v_s2, v_s3, out_v_q;
	logic [SB-1:0] st_s1, st_s2, st_s3, status_q;
	logic [QB-1:0] q_s1;
	logic [DB-1:0] m_s1;
	logic [DB-1:0] r_s1, r_s2;
	logic          sign_s1, sign_s2, sign_s3;
	logic [PW-1:0] prod_s2;
	logic [VB-2:0] n_s3;
	logic [VB-1:0] value_q;

	logic adv_o, adv3, adv2, adv1, take;

	// config write decode
	logic [DB-1:0] wr_m;
	logic [4:0]    wr_b;
	logic [DB:0]   wr_t;

	assign cfg.ready = 1'b1;
	assign wr_m = cfg.data[DB-1:0];
	assign wr_b = gsbd_pkg::width_of_m(gsbd_pkg::DIVISOR_BITS_MAX'(wr_m));
	assign wr_t = ((DB+1)'(1) << wr_b) - {1'b0, wr_m};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= M_RST;
			b_q    <= BW'(B_RST);
			t_q    <= T_RST[DB-1:0];
			sign_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == gsbd_pkg::REG_GOLOMB_M) begin
				if (wr_m != '0) begin
					m_q <= wr_m;
					b_q <= BW'(wr_b);
					t_q <= wr_t[DB-1:0];
				end
			end else if (cfg.index == gsbd_pkg::REG_SIGN_MODE) begin
				sign_q <= cfg.data[0];
			end
		end
	end

	// handshake: stages advance when the next one is empty or moving
	assign adv_o = !out_v_q || result_out.ready;
	assign adv3  = !v_s3 || adv_o;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign bits_in.ready = adv1;
	assign take  = bits_in.valid && adv1;

	// shared decode terms
	logic [DB:0]   acc_shift;
	logic [BW-1:0] rd_inc;
	logic          rem_full, plain_ok, unary_plain, ext_low;
	logic [DB+1:0] v_ext;

	assign acc_shift   = {acc_q[DB-1:0], bits_in.code_bit};
	assign rd_inc      = rd_q + 1'b1;
	assign rem_full    = rd_inc >= b_q;
	assign plain_ok    = !m_q[0] || (acc_shift < {1'b0, t_q});
	assign unary_plain = !m_q[0] || (t_q != '0);
	assign v_ext       = {acc_q, bits_in.code_bit};
	assign ext_low     = v_ext < {2'b00, t_q};

	// word end events
	logic          fin;
	logic [SB-1:0] fin_st;
	logic [DB+1:0] r_cand;
	logic          r_chk;

	always_comb begin
		fin    = 1'b0;
		fin_st = gsbd_pkg::ST_OK;
		r_cand = '0;
		r_chk  = 1'b0;
		if (bits_in.stream_end) begin
			fin    = ws_q;
			fin_st = gsbd_pkg::ST_END;
		end else begin
			unique case (ph_q)
				gsbd_pkg::PH_REM: begin
					if (rem_full && plain_ok) begin
						r_chk  = 1'b1;
						r_cand = {1'b0, acc_shift};
					end
				end
				gsbd_pkg::PH_EXTRA: begin
					if (ext_low) begin
						fin    = 1'b1;
						fin_st = gsbd_pkg::ST_REM;
					end else begin
						r_chk  = 1'b1;
						r_cand = v_ext - {2'b00, t_q};
					end
				end
				default: begin
					if (!bits_in.code_bit && b_q == '0 && unary_plain) begin
						r_chk = 1'b1;
					end
				end
			endcase
			if (r_chk) begin
				fin    = 1'b1;
				fin_st = (r_cand >= {2'b00, m_q}) ? gsbd_pkg::ST_REM : gsbd_pkg::ST_OK;
			end
		end
	end

	// next word state
	always_comb begin
		ph_d   = ph_q;
		quot_d = quot_q;
		acc_d  = acc_q;
		rd_d   = rd_q;
		ws_d   = ws_q;
		if (bits_in.stream_end || fin) begin
			ph_d   = gsbd_pkg::PH_UNARY;
			quot_d = '0;
			acc_d  = '0;
			rd_d   = '0;
			ws_d   = 1'b0;
		end else begin
			ws_d = 1'b1;
			unique case (ph_q)
				gsbd_pkg::PH_REM: begin
					acc_d = acc_shift;
					rd_d  = rd_inc;
					if (rem_full) begin
						ph_d = gsbd_pkg::PH_EXTRA;
					end
				end
				gsbd_pkg::PH_EXTRA: begin
					ph_d = gsbd_pkg::PH_EXTRA;
				end
				default: begin
					if (bits_in.code_bit) begin
						if (quot_q != '1) begin
							quot_d = quot_q + 1'b1;
						end
					end else begin
						acc_d = '0;
						rd_d  = '0;
						ph_d  = (b_q == '0) ? gsbd_pkg::PH_EXTRA : gsbd_pkg::PH_REM;
					end
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= gsbd_pkg::PH_UNARY;
			quot_q  <= '0;
			acc_q   <= '0;
			rd_q    <= '0;
			ws_q    <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				ph_q   <= ph_d;
				quot_q <= quot_d;
				acc_q  <= acc_d;
				rd_q   <= rd_d;
				ws_q   <= ws_d;
			end
			if (adv1) begin
				v_s1 <= take && fin;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv_o) begin
				out_v_q <= v_s3;
			end
		end
	end

	// stage terms
	logic [NW-1:0] n_full;
	logic          ovf;
	logic [VB-2:0] mag;
	logic [VB-1:0] mapped;

	assign n_full = NW'(prod_s2) + NW'(r_s2);
	assign ovf    = n_full > NW'(gsbd_pkg::VALUE_LIMIT);
	assign mag    = {1'b0, n_s3[VB-2:1]};

	// signed mapping of the decoded number
	always_comb begin
		if (st_s3 != gsbd_pkg::ST_OK) begin
			mapped = '0;
		end else if (!n_s3[0]) begin
			mapped = {1'b0, mag};
		end else if (!sign_s3) begin
			mapped = -{1'b0, mag};
		end else begin
			mapped = ~{1'b0, mag};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv1) begin
			st_s1   <= fin_st;
			q_s1    <= quot_q;
			m_s1    <= m_q;
			r_s1    <= r_cand[DB-1:0];
			sign_s1 <= sign_q;
		end
		if (adv2) begin
			st_s2   <= st_s1;
			prod_s2 <= PW'(q_s1) * PW'(m_s1);
			r_s2    <= r_s1;
			sign_s2 <= sign_s1;
		end
		if (adv3) begin
			st_s3   <= (st_s2 == gsbd_pkg::ST_OK && ovf) ? gsbd_pkg::ST_OVF : st_s2;
			n_s3    <= n_full[VB-2:0];
			sign_s3 <= sign_s2;
		end
		if (adv_o) begin
			status_q <= st_s3;
			value_q  <= mapped;
		end
	end

	assign result_out.valid         = out_v_q;
	assign result_out.decoded_value = value_q;
	assign result_out.status        = status_q;

endmodule
